### design/cscd_pkg.sv
// ----------------------------------------------------------------------------
// cscd_pkg
// Shared types, codes and tables for the clock set and display controller.
// ----------------------------------------------------------------------------
package cscd_pkg;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEG_W   = 8;
    localparam int BLINK_W = 7;

    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;

    localparam logic [BLINK_W-1:0] BLINK_THRESHOLD_RST = 7'd40;
    localparam logic [BLINK_W-1:0] BLINK_WRAP_RST      = 7'd80;

    typedef logic [HOUR_W-1:0]  hour_t;
    typedef logic [MIN_W-1:0]   minute_t;
    typedef logic [SEG_W-1:0]   seg_t;
    typedef logic [BLINK_W-1:0] blink_t;

    // configuration register index
    typedef enum logic [0:0] {
        CFG_BLINK_THRESHOLD = 1'b0,
        CFG_BLINK_WRAP      = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_HOUR   = 2'd1,
        MODE_MINUTE = 2'd2
    } mode_t;

    typedef struct packed {
        blink_t threshold;
        blink_t wrap;
    } cscd_cfg_t;

    typedef struct packed {
        hour_t   cur_hour;
        minute_t cur_minute;
        logic    set_key_level;
        logic    adjust_key_level;
    } cscd_sample_t;

    typedef struct packed {
        seg_t    digit0_segments;
        seg_t    digit1_segments;
        seg_t    digit2_segments;
        seg_t    digit3_segments;
        logic    write_time;
        hour_t   new_hour;
        minute_t new_minute;
    } cscd_result_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } bcd_pair_t;

    // seven-segment pattern per digit, anything else is blank
    function automatic seg_t seg_pattern(input logic [3:0] digit);
        seg_t pat;
        case (digit)
            4'd0:    pat = 8'hF9;
            4'd1:    pat = 8'h60;
            4'd2:    pat = 8'hDA;
            4'd3:    pat = 8'hF2;
            4'd4:    pat = 8'h63;
            4'd5:    pat = 8'hB3;
            4'd6:    pat = 8'hBB;
            4'd7:    pat = 8'hE0;
            4'd8:    pat = 8'hFB;
            4'd9:    pat = 8'hF3;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    // tens and units of a value below 64
    function automatic bcd_pair_t split_decimal(input logic [MIN_W-1:0] value);
        bcd_pair_t   res;
        logic [2:0]  tens;
        logic [MIN_W-1:0] rem;
        if (value >= 6'd60)
            tens = 3'd6;
        else if (value >= 6'd50)
            tens = 3'd5;
        else if (value >= 6'd40)
            tens = 3'd4;
        else if (value >= 6'd30)
            tens = 3'd3;
        else if (value >= 6'd20)
            tens = 3'd2;
        else if (value >= 6'd10)
            tens = 3'd1;
        else
            tens = 3'd0;
        rem = value - MIN_W'({3'd0, tens} * 6'd10);
        res.tens  = tens;
        res.units = rem[3:0];
        return res;
    endfunction

endpackage

### design/cscd_if.sv
// ----------------------------------------------------------------------------
// cscd channel interfaces
// Valid/ready channels for the time sample and the display result.
// ----------------------------------------------------------------------------
interface cscd_in_if;
    logic              valid;
    logic              ready;
    cscd_pkg::hour_t   cur_hour;
    cscd_pkg::minute_t cur_minute;
    logic              set_key_level;
    logic              adjust_key_level;

    modport source (
        output valid, cur_hour, cur_minute, set_key_level, adjust_key_level,
        input  ready
    );
    modport sink (
        input  valid, cur_hour, cur_minute, set_key_level, adjust_key_level,
        output ready
    );
endinterface

interface cscd_out_if;
    logic              valid;
    logic              ready;
    cscd_pkg::seg_t    digit0_segments;
    cscd_pkg::seg_t    digit1_segments;
    cscd_pkg::seg_t    digit2_segments;
    cscd_pkg::seg_t    digit3_segments;
    logic              write_time;
    cscd_pkg::hour_t   new_hour;
    cscd_pkg::minute_t new_minute;

    modport source (
        output valid, digit0_segments, digit1_segments, digit2_segments,
               digit3_segments, write_time, new_hour, new_minute,
        input  ready
    );
    modport sink (
        input  valid, digit0_segments, digit1_segments, digit2_segments,
               digit3_segments, write_time, new_hour, new_minute,
        output ready
    );
endinterface

### design/clock_set_and_display_ctrl_top.sv
// ----------------------------------------------------------------------------
// clock_set_and_display_ctrl_top
// Clock time setting and four-digit seven-segment display controller.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one request per pass: current hour and minute from the
//   real-time clock and the raw levels of the set and adjust keys.
//   display returns one result per request: four segment patterns, the hour
//   and minute after adjustment, and write_time when the new time (seconds
//   zeroed) must be written back to the clock chip.
//   An accepted request's result is registered; throughput is one request
//   per cycle while sample.ready is high. Key, mode and digit logic all sit
//   in one combinational pass ahead of the output register.
//   A two-entry output buffer keeps sample ready for one more request when
//   display stalls; sample.ready drops only while both entries are full.
//   Reset clears the mode to off, the key and pending flags, the blink
//   counter, and loads blink_threshold 40 and blink_wrap 80.
//   cfg_wr_en writes cfg_wdata into register cfg_index (0 threshold,
//   1 wrap) at the clock edge; write only while no request is in flight.
// ----------------------------------------------------------------------------
module clock_set_and_display_ctrl_top (
    input  logic                  clk,
    input  logic                  rst_n,
    cscd_in_if.sink               sample,
    cscd_out_if.source            display,
    input  logic                  cfg_wr_en,
    input  cscd_pkg::cfg_index_t  cfg_index,
    input  cscd_pkg::blink_t      cfg_wdata
);
    import cscd_pkg::*;

    blink_t       threshold_reg;
    blink_t       wrap_reg;
    cscd_cfg_t    cfg;
    cscd_sample_t sample_data;
    cscd_result_t result;
    cscd_result_t out_data;
    logic         accept;
    logic         in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= BLINK_THRESHOLD_RST;
            wrap_reg      <= BLINK_WRAP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BLINK_THRESHOLD: threshold_reg <= cfg_wdata;
                CFG_BLINK_WRAP:      wrap_reg      <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.wrap      = wrap_reg;

    assign sample_data.cur_hour         = sample.cur_hour;
    assign sample_data.cur_minute       = sample.cur_minute;
    assign sample_data.set_key_level    = sample.set_key_level;
    assign sample_data.adjust_key_level = sample.adjust_key_level;

    assign sample.ready = in_ready;
    assign accept       = sample.valid & in_ready;

    cscd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .sample (sample_data),
        .result (result)
    );

    cscd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (in_ready),
        .in_data   (result),
        .out_valid (display.valid),
        .out_ready (display.ready),
        .out_data  (out_data)
    );

    assign display.digit0_segments = out_data.digit0_segments;
    assign display.digit1_segments = out_data.digit1_segments;
    assign display.digit2_segments = out_data.digit2_segments;
    assign display.digit3_segments = out_data.digit3_segments;
    assign display.write_time      = out_data.write_time;
    assign display.new_hour        = out_data.new_hour;
    assign display.new_minute      = out_data.new_minute;

endmodule

### design/cscd_core.sv
// ----------------------------------------------------------------------------
// cscd_core
// Key release detection, mode sequencing, time adjust and digit encoding.
// ----------------------------------------------------------------------------
module cscd_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cscd_pkg::cscd_cfg_t    cfg,
    input  logic                   accept,
    input  cscd_pkg::cscd_sample_t sample,
    output cscd_pkg::cscd_result_t result
);
    import cscd_pkg::*;

    mode_t  mode_reg, mode_next;
    logic   pending_reg, pending_next;
    blink_t blink_reg, blink_next;
    logic   set_held_reg, set_held_next;
    logic   adj_held_reg, adj_held_next;

    mode_t     mode_mid;
    logic      pending_mid;
    logic      apply;
    logic      blank;
    hour_t     hour_adj;
    minute_t   minute_adj;
    bcd_pair_t hour_dec;
    bcd_pair_t minute_dec;

    always_comb
    begin
        // a key counts when released after being held
        adj_held_next = ~sample.adjust_key_level;
        set_held_next = ~sample.set_key_level;
        pending_mid   = pending_reg | (sample.adjust_key_level & adj_held_reg);

        mode_mid = mode_reg;
        if (sample.set_key_level && set_held_reg)
        begin
            case (mode_reg)
                MODE_OFF:    mode_mid = MODE_HOUR;
                MODE_HOUR:   mode_mid = MODE_MINUTE;
                MODE_MINUTE: mode_mid = MODE_OFF;
                default:     mode_mid = MODE_OFF;
            endcase
        end
        mode_next = mode_mid;

        apply        = (mode_mid != MODE_OFF) && pending_mid;
        pending_next = pending_mid & ~apply;

        hour_adj   = sample.cur_hour;
        minute_adj = sample.cur_minute;
        if (apply && mode_mid == MODE_HOUR)
            hour_adj = (sample.cur_hour >= HOUR_MAX) ? '0 : sample.cur_hour + 5'd1;
        if (apply && mode_mid == MODE_MINUTE)
            minute_adj = (sample.cur_minute >= MIN_MAX) ? '0 : sample.cur_minute + 6'd1;

        blank      = blink_reg > cfg.threshold;
        blink_next = (blink_reg > cfg.wrap) ? '0 : blink_reg + 7'd1;

        hour_dec   = split_decimal({1'b0, hour_adj});
        minute_dec = split_decimal(minute_adj);

        if (blank && mode_mid == MODE_HOUR)
        begin
            result.digit0_segments = '0;
            result.digit1_segments = '0;
        end
        else
        begin
            result.digit0_segments = seg_pattern({1'b0, hour_dec.tens});
            result.digit1_segments = seg_pattern(hour_dec.units);
        end
        if (blank && mode_mid == MODE_MINUTE)
        begin
            result.digit2_segments = '0;
            result.digit3_segments = '0;
        end
        else
        begin
            result.digit2_segments = seg_pattern({1'b0, minute_dec.tens});
            result.digit3_segments = seg_pattern(minute_dec.units);
        end
        result.write_time = apply;
        result.new_hour   = hour_adj;
        result.new_minute = minute_adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            pending_reg  <= 1'b0;
            blink_reg    <= '0;
            set_held_reg <= 1'b0;
            adj_held_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            pending_reg  <= pending_next;
            blink_reg    <= blink_next;
            set_held_reg <= set_held_next;
            adj_held_reg <= adj_held_next;
        end
    end

endmodule

### design/cscd_skid.sv
// ----------------------------------------------------------------------------
// cscd_skid
// Two-entry output buffer so the input side keeps flowing under a stall.
// ----------------------------------------------------------------------------
module cscd_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cscd_pkg::cscd_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cscd_pkg::cscd_result_t out_data
);
    import cscd_pkg::*;

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    cscd_result_t main_reg, main_next;
    cscd_result_t skid_reg, skid_next;
    logic         push;
    logic         pop;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        push            = in_valid & ~skid_valid_reg;
        pop             = main_valid_reg & out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = in_data;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_next       = in_data;
        end
        else if (push)
        begin
            // receiver stalled, park the request
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives time samples and key levels into the clock set and display
// controller, predicts mode, pending adjust, blink and segment outputs, and
// checks every display result in order under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import cscd_pkg::*;

    localparam seg_t SEG_BLANK = 8'h00;
    localparam seg_t SEG_TABLE [0:9] = '{8'hF9, 8'h60, 8'hDA, 8'hF2, 8'h63,
                                         8'hB3, 8'hBB, 8'hE0, 8'hFB, 8'hF3};
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 7;

    class time_setter_scoreboard;
        cscd_result_t expected_results[$];
        blink_t       threshold;
        blink_t       wrap;
        mode_t        mode;
        bit           adjust_pending;
        blink_t       blink_count;
        bit           set_held;
        bit           adjust_held;
        int           failures;
        int           mismatches;

        function new();
            threshold      = BLINK_THRESHOLD_RST;
            wrap           = BLINK_WRAP_RST;
            mode           = MODE_OFF;
            adjust_pending = 0;
            blink_count    = '0;
            set_held       = 0;
            adjust_held    = 0;
            failures       = 0;
            mismatches     = 0;
        endfunction

        function void set_register(cfg_index_t idx, blink_t value);
            if (idx == CFG_BLINK_THRESHOLD)
                threshold = value;
            else
                wrap = value;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        function void note_sample(cscd_sample_t s);
            int           hr;
            int           mn;
            bit           blank_hr;
            bit           blank_mn;
            cscd_result_t r;
            hr = int'(s.cur_hour);
            mn = int'(s.cur_minute);
            r.write_time = 1'b0;
            // adjust key first, so a release in off mode only leaves it pending
            if (!s.adjust_key_level && !adjust_held)
                adjust_held = 1;
            else if (s.adjust_key_level && adjust_held)
            begin
                adjust_held    = 0;
                adjust_pending = 1;
            end
            if (!s.set_key_level && !set_held)
                set_held = 1;
            else if (s.set_key_level && set_held)
            begin
                set_held = 0;
                mode = (mode == MODE_MINUTE) ? MODE_OFF : mode_t'(mode + 2'd1);
            end
            if (mode != MODE_OFF && adjust_pending)
            begin
                if (mode == MODE_HOUR)
                    hr = (hr >= 23) ? 0 : hr + 1;
                else
                    mn = (mn >= 59) ? 0 : mn + 1;
                adjust_pending = 0;
                r.write_time   = 1'b1;
            end
            blank_hr = (mode == MODE_HOUR) && (blink_count > threshold);
            blank_mn = (mode == MODE_MINUTE) && (blink_count > threshold);
            r.digit0_segments = blank_hr ? SEG_BLANK : SEG_TABLE[hr / 10];
            r.digit1_segments = blank_hr ? SEG_BLANK : SEG_TABLE[hr % 10];
            r.digit2_segments = blank_mn ? SEG_BLANK : SEG_TABLE[mn / 10];
            r.digit3_segments = blank_mn ? SEG_BLANK : SEG_TABLE[mn % 10];
            r.new_hour   = hour_t'(hr);
            r.new_minute = minute_t'(mn);
            // 7-bit counter, wraps from 127 to 0 when the wrap point is 127
            blink_count = (blink_count > wrap) ? blink_t'(0) : blink_count + 7'd1;
            expected_results.push_back(r);
        endfunction

        function void report(string what, logic [7:0] exp_v, logic [7:0] got_v);
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
        endfunction

        function void check_result(cscd_result_t got);
            cscd_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                report("unexpected result", 8'h00, got.digit0_segments);
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.digit0_segments !== exp_r.digit0_segments)
                report("digit0_segments", exp_r.digit0_segments, got.digit0_segments);
            if (got.digit1_segments !== exp_r.digit1_segments)
                report("digit1_segments", exp_r.digit1_segments, got.digit1_segments);
            if (got.digit2_segments !== exp_r.digit2_segments)
                report("digit2_segments", exp_r.digit2_segments, got.digit2_segments);
            if (got.digit3_segments !== exp_r.digit3_segments)
                report("digit3_segments", exp_r.digit3_segments, got.digit3_segments);
            if (got.write_time !== exp_r.write_time)
                report("write_time", 8'(exp_r.write_time), 8'(got.write_time));
            if (got.new_hour !== exp_r.new_hour)
                report("new_hour", 8'(exp_r.new_hour), 8'(got.new_hour));
            if (got.new_minute !== exp_r.new_minute)
                report("new_minute", 8'(exp_r.new_minute), 8'(got.new_minute));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    blink_t     cfg_wdata;

    cscd_in_if  sample();
    cscd_out_if display();

    time_setter_scoreboard time_board;

    int set_press_left;
    int adjust_press_left;
    bit no_idle_phase;

    clock_set_and_display_ctrl_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .display   (display),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic cscd_sample_t make_sample(int hr, int mn, bit set_lvl, bit adj_lvl);
        cscd_sample_t s;
        s.cur_hour         = hour_t'(hr);
        s.cur_minute       = minute_t'(mn);
        s.set_key_level    = set_lvl;
        s.adjust_key_level = adj_lvl;
        return s;
    endfunction

    // mostly clean press and release sequences, some raw noise on the keys
    function automatic cscd_sample_t random_sample();
        cscd_sample_t s;
        int           pick;
        pick = $urandom_range(0, 9);
        s.cur_hour   = (pick == 0) ? hour_t'($urandom_range(0, 31)) :
                       (pick == 1) ? hour_t'(23) : hour_t'($urandom_range(0, 23));
        pick = $urandom_range(0, 9);
        s.cur_minute = (pick == 0) ? minute_t'($urandom_range(0, 63)) :
                       (pick == 1) ? minute_t'(59) : minute_t'($urandom_range(0, 59));
        if (set_press_left == 0 && $urandom_range(0, 11) == 0)
            set_press_left = $urandom_range(1, 4);
        if (adjust_press_left == 0 && $urandom_range(0, 2) == 0)
            adjust_press_left = $urandom_range(1, 3);
        s.set_key_level    = (set_press_left == 0);
        s.adjust_key_level = (adjust_press_left == 0);
        if (set_press_left > 0)
            set_press_left--;
        if (adjust_press_left > 0)
            adjust_press_left--;
        if ($urandom_range(0, 9) == 0)
        begin
            s.set_key_level    = 1'($urandom_range(0, 1));
            s.adjust_key_level = 1'($urandom_range(0, 1));
        end
        return s;
    endfunction

    task automatic send_item(input cscd_sample_t s);
        sample.valid            <= 1'b1;
        sample.cur_hour         <= s.cur_hour;
        sample.cur_minute       <= s.cur_minute;
        sample.set_key_level    <= s.set_key_level;
        sample.adjust_key_level <= s.adjust_key_level;
        do
            @(posedge clk);
        while (!sample.ready);
        time_board.note_sample(s);
    endtask

    task automatic sender_gap(input int cycles);
        sample.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold requests until every expected result is back
    task automatic drain_results();
        sample.valid <= 1'b0;
        while (time_board.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input blink_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        time_board.set_register(idx, value);
    endtask

    task automatic run_directed();
        send_item(make_sample(0, 0, 1, 1));
        send_item(make_sample(23, 59, 1, 1));
        send_item(make_sample(31, 63, 1, 1));
        // adjust press and release while off stays pending
        send_item(make_sample(12, 34, 1, 0));
        send_item(make_sample(12, 34, 1, 1));
        send_item(make_sample(12, 34, 1, 1));
        send_item(make_sample(23, 34, 0, 1));
        send_item(make_sample(23, 34, 1, 1));
        send_item(make_sample(31, 5, 1, 0));
        send_item(make_sample(31, 5, 1, 1));
        send_item(make_sample(5, 59, 0, 1));
        send_item(make_sample(5, 59, 1, 1));
        send_item(make_sample(5, 59, 1, 0));
        send_item(make_sample(5, 59, 1, 1));
        send_item(make_sample(5, 63, 1, 0));
        send_item(make_sample(5, 63, 1, 1));
        // both keys released together in minute mode
        send_item(make_sample(7, 7, 0, 0));
        send_item(make_sample(7, 7, 1, 1));
        send_item(make_sample(8, 8, 0, 1));
        send_item(make_sample(8, 8, 1, 1));
        send_item(make_sample(8, 8, 1, 1));
        send_item(make_sample(16, 42, 0, 1));
        send_item(make_sample(16, 42, 1, 1));
        send_item(make_sample(16, 42, 0, 1));
        send_item(make_sample(16, 42, 1, 1));
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < count)
            begin
                send_item(random_sample());
                burst--;
                sent++;
            end
            if ($urandom_range(0, 59) == 0)
                drain_results();
            else if (!no_idle_phase && $urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 6));
        end
    endtask

    // receiver: changing stall styles plus a long hold after 400 results, then every 800
    initial
    begin
        int seen;
        int tick;
        int style;
        int next_hold;
        cscd_result_t got;
        seen      = 0;
        tick      = 0;
        style     = 0;
        next_hold = 400;
        display.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (display.valid && display.ready)
            begin
                got.digit0_segments = display.digit0_segments;
                got.digit1_segments = display.digit1_segments;
                got.digit2_segments = display.digit2_segments;
                got.digit3_segments = display.digit3_segments;
                got.write_time      = display.write_time;
                got.new_hour        = display.new_hour;
                got.new_minute      = display.new_minute;
                time_board.check_result(got);
                seen++;
            end
            tick++;
            if (tick % 64 == 0)
                style = $urandom_range(0, 3);
            if (seen >= next_hold)
            begin
                next_hold += 800;
                display.ready <= 1'b0;
                repeat (150) @(posedge clk);
            end
            else
            begin
                case (style)
                    0:       display.ready <= 1'b1;
                    1:       display.ready <= tick[0];
                    2:       display.ready <= ($urandom_range(0, 3) != 0);
                    default: display.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        blink_t thr_set [NUM_PHASES];
        blink_t wrap_set [NUM_PHASES];
        thr_set  = '{7'd40, 7'd0, 7'd127, 7'd127, 7'd5, 7'd63, 7'd0};
        wrap_set = '{7'd80, 7'd0, 7'd127, 7'd126, 7'd20, 7'd127, 7'd126};
        time_board        = new();
        set_press_left    = 0;
        adjust_press_left = 0;
        no_idle_phase     = 0;
        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_index               <= CFG_BLINK_THRESHOLD;
        cfg_wdata               <= '0;
        sample.valid            <= 1'b0;
        sample.cur_hour         <= '0;
        sample.cur_minute       <= '0;
        sample.set_key_level    <= 1'b1;
        sample.adjust_key_level <= 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(PHASE_ITEMS);
        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            repeat (3) @(posedge clk);
            if (ph == NUM_PHASES - 1)
                thr_set[ph] = blink_t'($urandom_range(0, 127));
            write_register(CFG_BLINK_THRESHOLD, thr_set[ph]);
            write_register(CFG_BLINK_WRAP, wrap_set[ph]);
            no_idle_phase = (ph == 2);
            run_random(PHASE_ITEMS);
        end
        drain_results();
        repeat (5) @(posedge clk);
        if (time_board.failures == 0 && time_board.pending_count() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
